[hw/rtl/bbs_pkg.sv]
// ---------------------------------------------------------------------------
// bbs_pkg
// Request, result and internal side-band types for the Brownian bridge sampler.
// ---------------------------------------------------------------------------
package bbs_pkg;

  typedef struct packed {
    logic               action;
    logic signed [63:0] sample_time;
    logic signed [63:0] lo_time;
    logic signed [31:0] lo_value;
    logic signed [63:0] hi_time;
    logic signed [31:0] hi_value;
    logic signed [15:0] normal_draw;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               status;
  } out_t;

  // Fields that ride along the arithmetic pipeline
  typedef struct packed {
    logic               bad;
    logic               bridge;
    logic               neg;
    logic signed [31:0] lo_value;
    logic signed [15:0] draw;
    logic [63:0]        h;
    logic [32:0]        mag;
  } side_t;

  localparam logic ACT_PLAIN  = 1'b0;
  localparam logic ACT_BRIDGE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ORDER = 1'b1;

  localparam logic [46:0] NS_PER_DAY = 47'd86400000000000;

  // ns per day = 2^DAY_SHIFT * DAY_ODD
  localparam int          DAY_SHIFT = 16;
  localparam logic [30:0] DAY_ODD   = 31'd1318359375;

endpackage

[hw/rtl/bbs_div_pipe.sv]
// ---------------------------------------------------------------------------
// bbs_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The top DW numerator bits must be below the divisor.
// ---------------------------------------------------------------------------
module bbs_div_pipe #(
  parameter int DW     = 64,
  parameter int QW     = 64,
  parameter int LANES  = 1,
  parameter int SIDE_W = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [LANES-1:0][DW+QW-1:0]     in_num,
  input  logic [DW-1:0]                   in_den,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [LANES-1:0][QW-1:0]        out_quo,
  output logic [SIDE_W-1:0]               out_side
);

  localparam int NW = DW + QW;

  function automatic logic [NW-1:0] div_step(input logic [NW-1:0] w, input logic [DW-1:0] d);
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] r;
    t  = w[NW-1:QW-1];
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {r[DW-1:0], w[QW-2:0], ge};
  endfunction

  logic [QW-1:0]              vld_r;
  logic [LANES-1:0][NW-1:0]   work_r [QW];
  logic [DW-1:0]              den_r  [QW];
  logic [SIDE_W-1:0]          side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     prev_v;
    logic [LANES-1:0][NW-1:0] prev_w;
    logic [DW-1:0]            prev_d;
    logic [SIDE_W-1:0]        prev_s;

    if (k == 0) begin : g_first
      assign prev_v = in_valid;
      assign prev_w = in_num;
      assign prev_d = in_den;
      assign prev_s = in_side;
    end else begin : g_next
      assign prev_v = vld_r[k-1];
      assign prev_w = work_r[k-1];
      assign prev_d = den_r[k-1];
      assign prev_s = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= prev_d;
        side_r[k] <= prev_s;
        for (int l = 0; l < LANES; l++) begin
          work_r[k][l] <= div_step(prev_w[l], prev_d);
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quo[l] = work_r[QW-1][l][QW-1:0];
  end

  assign out_valid = vld_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

[hw/rtl/bbs_sqrt_pipe.sv]
// ---------------------------------------------------------------------------
// bbs_sqrt_pipe
// Pipelined integer square root (floor), one root bit per stage.
// ---------------------------------------------------------------------------
module bbs_sqrt_pipe #(
  parameter int RW     = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int XW = 2 * RW;

  logic [RW-1:0]     vld_r;
  logic [RW:0]       rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [XW-1:0]     x_r    [RW];
  logic [SIDE_W-1:0] side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              prev_v;
    logic [RW:0]       prev_rem;
    logic [RW-1:0]     prev_root;
    logic [XW-1:0]     prev_x;
    logic [SIDE_W-1:0] prev_s;
    logic [RW+2:0]     t;
    logic [RW+2:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign prev_v    = in_valid;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_x    = in_x;
      assign prev_s    = in_side;
    end else begin : g_next
      assign prev_v    = vld_r[k-1];
      assign prev_rem  = rem_r[k-1];
      assign prev_root = root_r[k-1];
      assign prev_x    = x_r[k-1];
      assign prev_s    = side_r[k-1];
    end

    assign t     = {prev_rem, prev_x[XW-1:XW-2]};
    assign trial = {1'b0, prev_root, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (RW+1)'(t - trial) : t[RW:0];
        root_r[k] <= {prev_root[RW-2:0], ge};
        x_r[k]    <= {prev_x[XW-3:0], 2'b00};
        side_r[k] <= prev_s;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

[hw/rtl/brownian_bridge_sampler.sv]
// Throughput: one request per cycle; the 64-stage span divider and the square-root
// pipeline retire one bit per stage, the per-day divide is a five-stage reciprocal multiply.
// Any output stall freezes the whole pipeline.
// Reset (synchronous, rst_n low) empties the pipeline and sets the variance to 1.0.
// ---------------------------------------------------------------------------
// brownian_bridge_sampler
// Plain and bridge Brownian samples with exact integer variance and saturation.
// ---------------------------------------------------------------------------
module brownian_bridge_sampler #(
  parameter int VALUE_FRAC_BITS = 16,
  parameter int DRAW_FRAC_BITS  = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bbs_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data
);

  localparam int          SIDE_W    = $bits(bbs_pkg::side_t);
  localparam int          CQW       = 50 + VALUE_FRAC_BITS;
  localparam int          MW        = 80 + VALUE_FRAC_BITS;
  localparam int          LM        = (MW + 31) / 32;
  localparam int          LR        = (CQW + 31) / 32;
  localparam int          RSW       = 32 * (LR + 1);
  localparam int          PRW       = 32 * (LM + LR);
  localparam int          SRW       = (CQW + 1) / 2;
  localparam int          SUMW      = SRW + 20;
  localparam logic [31:0] VAR_RESET = 32'(1) << VALUE_FRAC_BITS;
  // floor(2^MW / DAY_ODD); the product estimate is at most one below the quotient
  localparam logic [LR*32-1:0] RECIP =
    (LR*32)'(((MW+1)'(1) << MW) / bbs_pkg::DAY_ODD);

  logic en;
  logic out_valid_r;
  bbs_pkg::out_t out_r;
  logic [31:0] var_r;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_r <= VAR_RESET;
    end else if (cfg_we) begin
      var_r <= cfg_data;
    end
  end

  // Stage 0: request register
  logic s0_v_r;
  bbs_pkg::in_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= in_data;
    end
  end

  // Stage 1: ordering check and spans
  logic              s1_bad;
  logic [63:0]       s1_d1, s1_d2, s1_len;
  logic signed [32:0] s1_diff;
  logic [32:0]       s1_abs;
  always_comb begin
    if (s0_r.action == bbs_pkg::ACT_BRIDGE) begin
      s1_bad = !(s0_r.lo_time < s0_r.hi_time && s0_r.lo_time <= s0_r.sample_time &&
                 s0_r.sample_time <= s0_r.hi_time);
    end else begin
      s1_bad = s0_r.sample_time < s0_r.lo_time;
    end
    s1_d1   = s0_r.sample_time - s0_r.lo_time;
    s1_d2   = s0_r.hi_time - s0_r.sample_time;
    s1_len  = s0_r.hi_time - s0_r.lo_time;
    s1_diff = {s0_r.hi_value[31], s0_r.hi_value} - {s0_r.lo_value[31], s0_r.lo_value};
    s1_abs  = s1_diff[32] ? 33'(-s1_diff) : 33'(s1_diff);
  end

  logic s1_v_r;
  logic [63:0] d1_r, d2_r, len1_r;
  logic [32:0] abs_r;
  bbs_pkg::side_t s1_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r               <= s1_d1;
      d2_r               <= s1_d2;
      len1_r             <= s1_len;
      abs_r              <= s1_abs;
      s1_side_r.bad      <= s1_bad;
      s1_side_r.bridge   <= s0_r.action;
      s1_side_r.neg      <= s1_diff[32];
      s1_side_r.lo_value <= s0_r.lo_value;
      s1_side_r.draw     <= s0_r.normal_draw;
      s1_side_r.h        <= s1_d1;
      s1_side_r.mag      <= '0;
    end
  end

  // Stage 2: 32x32 partial products
  logic s2_v_r;
  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [64:0] qa_r, qb_r;
  logic [63:0] len2_r;
  bbs_pkg::side_t s2_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r    <= d1_r[31:0]  * d2_r[31:0];
      pp01_r    <= d1_r[31:0]  * d2_r[63:32];
      pp10_r    <= d1_r[63:32] * d2_r[31:0];
      pp11_r    <= d1_r[63:32] * d2_r[63:32];
      qa_r      <= abs_r * d1_r[31:0];
      qb_r      <= abs_r * d1_r[63:32];
      len2_r    <= len1_r;
      s2_side_r <= s1_side_r;
    end
  end

  // Stage 3: assemble the 128-bit numerators
  logic s3_v_r;
  logic [1:0][127:0] num_r;
  logic [63:0] len3_r;
  bbs_pkg::side_t s3_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= {64'b0, pp00_r} + {32'b0, pp01_r, 32'b0} + {32'b0, pp10_r, 32'b0}
                 + {pp11_r, 64'b0};
      num_r[1]  <= {63'b0, qa_r} + {31'b0, qb_r, 32'b0};
      len3_r    <= len2_r;
      s3_side_r <= s2_side_r;
    end
  end

  // Span divider: bridge variance time and drift magnitude
  logic dv_v;
  logic [1:0][63:0] dv_q;
  logic [SIDE_W-1:0] dv_side_raw;
  bbs_pkg::side_t dv_side;

  bbs_div_pipe #(.DW(64), .QW(64), .LANES(2), .SIDE_W(SIDE_W)) u_span_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s3_v_r),
    .in_num   (num_r),
    .in_den   (len3_r),
    .in_side  (s3_side_r),
    .out_valid(dv_v),
    .out_quo  (dv_q),
    .out_side (dv_side_raw)
  );
  assign dv_side = bbs_pkg::side_t'(dv_side_raw);

  // Stage 4: pick h, variance partial products
  logic [63:0] h_sel;
  assign h_sel = dv_side.bridge ? dv_q[0] : dv_side.h;

  // plain samples carry no drift
  bbs_pkg::side_t s4_side_nxt;
  always_comb begin
    s4_side_nxt     = dv_side;
    s4_side_nxt.mag = (dv_side.bridge == bbs_pkg::ACT_BRIDGE) ? dv_q[1][32:0] : '0;
  end

  logic s4_v_r;
  logic [63:0] pv0_r, pv1_r;
  bbs_pkg::side_t s4_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= dv_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pv0_r     <= var_r * h_sel[31:0];
      pv1_r     <= var_r * h_sel[63:32];
      s4_side_r <= s4_side_nxt;
    end
  end

  // Stage 5: V * h scaled by the value fraction, power-of-two part of a day removed
  logic s5_v_r;
  logic [MW-1:0] mnum_r;
  bbs_pkg::side_t s5_side_r;
  logic [95:0] s5_prod;
  assign s5_prod = {32'b0, pv0_r} + {pv1_r, 32'b0};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mnum_r    <= MW'({s5_prod, VALUE_FRAC_BITS'(0)} >> bbs_pkg::DAY_SHIFT);
      s5_side_r <= s4_side_r;
    end
  end

  // Divide by the odd part of a day: reciprocal multiply, then one correction
  logic [LM*32-1:0] m_pad;
  assign m_pad = (LM*32)'(mnum_r);

  logic dd1_v_r;
  logic [LM-1:0][LR-1:0][63:0] dd1_pp_r;
  logic [31:0] dd1_lo_r;
  bbs_pkg::side_t dd1_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd1_v_r <= 1'b0;
    end else if (en) begin
      dd1_v_r <= s5_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LM; i++) begin
        for (int j = 0; j < LR; j++) begin
          dd1_pp_r[i][j] <= m_pad[32*i +: 32] * RECIP[32*j +: 32];
        end
      end
      dd1_lo_r   <= mnum_r[31:0];
      dd1_side_r <= s5_side_r;
    end
  end

  logic [LM-1:0][RSW-1:0] dd2_row_nxt;
  always_comb begin
    for (int i = 0; i < LM; i++) begin
      dd2_row_nxt[i] = '0;
      for (int j = 0; j < LR; j++) begin
        dd2_row_nxt[i] = dd2_row_nxt[i] + (RSW'(dd1_pp_r[i][j]) << (32 * j));
      end
    end
  end

  logic dd2_v_r;
  logic [LM-1:0][RSW-1:0] dd2_row_r;
  logic [31:0] dd2_lo_r;
  bbs_pkg::side_t dd2_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd2_v_r <= 1'b0;
    end else if (en) begin
      dd2_v_r <= dd1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dd2_row_r  <= dd2_row_nxt;
      dd2_lo_r   <= dd1_lo_r;
      dd2_side_r <= dd1_side_r;
    end
  end

  logic [PRW-1:0] dd3_prod;
  always_comb begin
    dd3_prod = '0;
    for (int i = 0; i < LM; i++) begin
      dd3_prod = dd3_prod + (PRW'(dd2_row_r[i]) << (32 * i));
    end
  end

  logic dd3_v_r;
  logic [CQW-1:0] dd3_q_r;
  logic [31:0] dd3_lo_r;
  bbs_pkg::side_t dd3_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd3_v_r <= 1'b0;
    end else if (en) begin
      dd3_v_r <= dd2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dd3_q_r    <= dd3_prod[MW +: CQW];
      dd3_lo_r   <= dd2_lo_r;
      dd3_side_r <= dd2_side_r;
    end
  end

  // remainder below 2 * DAY_ODD, so its low 32 bits are enough
  logic [62:0] dd4_t;
  assign dd4_t = dd3_q_r[31:0] * bbs_pkg::DAY_ODD;

  logic dd4_v_r;
  logic [CQW-1:0] dd4_q_r;
  logic [31:0] dd4_t_r, dd4_lo_r;
  bbs_pkg::side_t dd4_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd4_v_r <= 1'b0;
    end else if (en) begin
      dd4_v_r <= dd3_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dd4_q_r    <= dd3_q_r;
      dd4_t_r    <= dd4_t[31:0];
      dd4_lo_r   <= dd3_lo_r;
      dd4_side_r <= dd3_side_r;
    end
  end

  logic [31:0] dd5_rem;
  assign dd5_rem = dd4_lo_r - dd4_t_r;

  logic dd5_v_r;
  logic [CQW-1:0] dd5_q_r;
  bbs_pkg::side_t dd5_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd5_v_r <= 1'b0;
    end else if (en) begin
      dd5_v_r <= dd4_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dd5_q_r    <= dd4_q_r + CQW'(dd5_rem >= {1'b0, bbs_pkg::DAY_ODD});
      dd5_side_r <= dd4_side_r;
    end
  end

  // Standard deviation
  logic sq_v;
  logic [SRW-1:0] sigma;
  logic [SIDE_W-1:0] sq_side_raw;
  bbs_pkg::side_t sq_side;

  bbs_sqrt_pipe #(.RW(SRW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dd5_v_r),
    .in_x     ((2*SRW)'(dd5_q_r)),
    .in_side  (dd5_side_r),
    .out_valid(sq_v),
    .out_root (sigma),
    .out_side (sq_side_raw)
  );
  assign sq_side = bbs_pkg::side_t'(sq_side_raw);

  // Stage 6: noise magnitude
  logic [15:0] zabs;
  assign zabs = sq_side.draw[15] ? 16'(-sq_side.draw) : 16'(sq_side.draw);

  logic s6_v_r;
  logic [SRW+15:0] nprod_r;
  bbs_pkg::side_t s6_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= sq_v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nprod_r   <= sigma * zabs;
      s6_side_r <= sq_side;
    end
  end

  // Stage 7: sum, saturate, result register
  logic signed [SUMW-1:0] s7_mean, s7_dx, s7_sum;
  logic [SRW+15:0]        s7_nmag;
  bbs_pkg::out_t          s7_out;
  always_comb begin
    s7_nmag = nprod_r >> DRAW_FRAC_BITS;
    s7_mean = s6_side_r.neg ? -$signed(SUMW'(s6_side_r.mag)) : $signed(SUMW'(s6_side_r.mag));
    s7_dx   = s6_side_r.draw[15] ? -$signed(SUMW'(s7_nmag)) : $signed(SUMW'(s7_nmag));
    s7_sum  = SUMW'(s6_side_r.lo_value) + s7_mean + s7_dx;
    if (s6_side_r.bad) begin
      s7_out.sample_value = s6_side_r.lo_value;
      s7_out.status       = bbs_pkg::STATUS_ORDER;
    end else begin
      s7_out.status = bbs_pkg::STATUS_OK;
      if (s7_sum > SUMW'(32'sh7FFFFFFF)) begin
        s7_out.sample_value = 32'sh7FFFFFFF;
      end else if (s7_sum < -SUMW'(33'sh080000000)) begin
        s7_out.sample_value = 32'sh80000000;
      end else begin
        s7_out.sample_value = s7_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s6_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= s7_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[tb/sv/tb_brownian_bridge_sampler.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_brownian_bridge_sampler
// Drives plain and bridge sample requests through the sampler with random
// stalls on both channels, predicts every result with exact wide-integer
// arithmetic and checks the outputs in order across several variance settings.
// ---------------------------------------------------------------------------
module tb_brownian_bridge_sampler;

  localparam int VFRAC = 16;
  localparam int DFRAC = 12;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  bbs_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  bbs_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [31:0]   cfg_data = '0;

  brownian_bridge_sampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  bbs_pkg::in_t  pending_reqs[$];
  bbs_pkg::out_t expected_samples[$];
  logic [31:0]   day_variance = 32'd65536;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            errors = 0;

  function automatic bbs_pkg::out_t predict_sample(bbs_pkg::in_t r);
    logic [63:0]        d1, d2, span, h, sig, zm, prod, c, magn;
    logic [127:0]       wide, q;
    logic signed [63:0] lv, hv, diff, mean, dx, v;
    logic signed [63:0] ts, tl, th;
    logic signed [15:0] z;
    logic               bad;
    bbs_pkg::out_t      o;
    ts = r.sample_time;
    tl = r.lo_time;
    th = r.hi_time;
    lv = $signed(r.lo_value);
    hv = $signed(r.hi_value);
    z  = r.normal_draw;
    if (r.action == bbs_pkg::ACT_BRIDGE) bad = !(tl < th && tl <= ts && ts <= th);
    else bad = ts < tl;
    if (bad) begin
      o.sample_value = r.lo_value;
      o.status = bbs_pkg::STATUS_ORDER;
      return o;
    end
    mean = 0;
    if (r.action == bbs_pkg::ACT_BRIDGE) begin
      d1 = ts - tl;
      d2 = th - ts;
      span = th - tl;
      wide = 128'(d1) * 128'(d2);
      q = wide / 128'(span);
      h = q[63:0];
      diff = hv - lv;
      magn = diff < 0 ? -diff : diff;
      q = (128'(magn) * 128'(d1)) / 128'(span);
      mean = diff < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    end else begin
      h = ts - tl;
    end
    wide = (128'(day_variance) * 128'(h)) << VFRAC;
    q = wide / 128'(bbs_pkg::NS_PER_DAY);
    sig = 0;
    for (int i = 63; i >= 0; i--) begin
      c = sig | (64'd1 << i);
      if (128'(c) * 128'(c) <= q) sig = c;
    end
    zm = z < 0 ? 64'(-64'sd1 * z) : 64'(z);
    prod = sig * zm;
    zm = prod >> DFRAC;
    dx = z < 0 ? -$signed(zm) : $signed(zm);
    v = lv + mean + dx;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    o.sample_value = v[31:0];
    o.status = bbs_pkg::STATUS_OK;
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bbs_pkg::in_t random_req();
    bbs_pkg::in_t r;
    logic [287:0] raw;
    logic [63:0]  span;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    r = raw[$bits(bbs_pkg::in_t)-1:0];
    if ($urandom_range(99) < 10) return r;  // noise: anything goes
    if ($urandom_range(3) == 0) r.lo_time = $signed(rand64() >> $urandom_range(63));
    span = rand64() >> $urandom_range(63);
    if (r.action == bbs_pkg::ACT_PLAIN) begin
      r.sample_time = r.lo_time + span;
    end else begin
      if (span == 0) span = 1;
      r.hi_time = r.lo_time + span;
      case ($urandom_range(9))
        0: r.sample_time = r.lo_time;
        1: r.sample_time = r.hi_time;
        default: r.sample_time = r.lo_time + (span == '1 ? rand64() : rand64() % (span + 1));
      endcase
    end
    return r;
  endfunction

  function automatic bbs_pkg::in_t make_req(logic act, logic signed [63:0] ts, tl, th,
                                            logic signed [31:0] lv, hv,
                                            logic signed [15:0] z);
    bbs_pkg::in_t r;
    r.action = act; r.sample_time = ts; r.lo_time = tl; r.hi_time = th;
    r.lo_value = lv; r.hi_value = hv; r.normal_draw = z;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: expectation is taken at acceptance, then the next request is offered
  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        expected_samples.push_back(predict_sample(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // Monitor
  always @(posedge clk) begin
    bbs_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result", out_data.sample_value, '0);
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample_value !== want.sample_value)
          report_mismatch("sample_value", out_data.sample_value, want.sample_value);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    logic [31:0] variances[6];
    variances = '{32'd65536, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd1, 32'd6553600};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= variances[p];
        day_variance = variances[p];
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      send_idle_pct = p < 2 ? 25 : (p < 4 ? 78 : 0);
      recv_idle_pct = p < 2 ? 78 : (p < 4 ? 25 : 0);
      if (p == 0) begin
        // bad ordering, zero span, widest span, bridge end points, draw and value extremes
        pending_reqs.push_back(make_req(bbs_pkg::ACT_PLAIN, -5, 10, 0, 32'sd100, 0,
          16'sd4096));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_PLAIN, 77, 77, 0, -32'sd5, 0,
          16'sd4096));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_PLAIN, 64'sh7FFF_FFFF_FFFF_FFFF,
          64'sh8000_0000_0000_0000, 0, 0, 0, 16'sh7FFF));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_PLAIN, 64'sh7FFF_FFFF_FFFF_FFFF,
          64'sh8000_0000_0000_0000, 0, 0, 0, 16'sh8000));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_PLAIN, 64'sd86400000000000, 0, -1,
          32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh7FFF));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_PLAIN, 64'sd86400000000000, 0, 5,
          32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 50, 50, 50, 32'sd7, 32'sd9,
          16'sd100));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 10, 20, 100, 32'sd7, 32'sd9,
          16'sd100));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 101, 20, 100, 32'sd7, 32'sd9,
          16'sd100));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 20, 20, 100, 32'sd7, 32'sd9,
          16'sh7FFF));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 100, 20, 100, 32'sd7, 32'sd9,
          16'sh8000));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 0, 64'sh8000_0000_0000_0000,
          64'sh7FFF_FFFF_FFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh7FFF));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 64'sd43200000000000, 0,
          64'sd86400000000000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000));
        pending_reqs.push_back(make_req(bbs_pkg::ACT_BRIDGE, 64'sh7FFF_FFFF_FFFF_FFFE,
          64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF, 0, -1, 16'sd0));
      end
      for (int i = 0; i < 240; i++) pending_reqs.push_back(random_req());
    end
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
